// ----- src/l2h_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the mix step function for the lookup2 stream hash
// no dependencies

package l2h_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned BLOCK_BYTES = 12;
    localparam int unsigned MIX_STEPS   = 9;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [WORD_W-1:0] SEED_A_RESET = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] SEED_B_RESET = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] SEED_C_RESET = 32'h0000_0000;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SEED_A = 2'd0;
    localparam t_cfg_idx REG_SEED_B = 2'd1;
    localparam t_cfg_idx REG_SEED_C = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } t_words;

    // one item of work moving through the mix pipeline
    typedef struct packed {
        logic   valid;
        logic   last;
        t_words words;
    } t_mix_item;

    localparam int unsigned MIX_SHIFT [MIX_STEPS] = '{13, 8, 13, 12, 16, 5, 3, 10, 15};

    // one of the nine subtract/xor/shift steps; step is a constant at each use
    function automatic t_words mix_step(input t_words w, input int unsigned step);
        t_words r;
        r = w;
        case (step)
            0, 3, 6: begin
                r.a = w.a - w.b - w.c;
                r.a = r.a ^ (w.c >> MIX_SHIFT[step]);
            end
            1, 4, 7: begin
                r.b = w.b - w.c - w.a;
                r.b = r.b ^ (w.a << MIX_SHIFT[step]);
            end
            2, 5, 8: begin
                r.c = w.c - w.a - w.b;
                r.c = r.c ^ (w.b >> MIX_SHIFT[step]);
            end
            default: begin
                r = w;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- src/l2h_mix_pipe.sv -----
`timescale 1ns / 1ps
// nine-stage mix pipeline, one subtract/xor/shift step per stage
// depends on l2h_pkg

module l2h_mix_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  l2h_pkg::t_mix_item   i_launch,
    output l2h_pkg::t_mix_item   o_done,
    output logic                 o_busy
);
    import l2h_pkg::*;

    t_mix_item r_stage [MIX_STEPS];
    t_mix_item w_in    [MIX_STEPS];

    for (genvar g = 0; g < MIX_STEPS; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_in[g] = i_launch;
        end else begin : g_next
            assign w_in[g] = r_stage[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage[g].valid <= 1'b0;
            end else begin
                r_stage[g].valid <= w_in[g].valid;
            end
            r_stage[g].last  <= w_in[g].last;
            r_stage[g].words <= mix_step(w_in[g].words, g);
        end
    end

    always_comb begin
        o_busy = 1'b0;
        for (int unsigned i = 0; i < MIX_STEPS; i++) begin
            o_busy = o_busy | r_stage[i].valid;
        end
    end

    assign o_done = r_stage[MIX_STEPS-1];

endmodule

// ----- src/l2h_absorb.sv -----
`timescale 1ns / 1ps
// input register, byte accumulation and mix launch for the lookup2 stream hash
// depends on l2h_pkg

module l2h_absorb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [l2h_pkg::BYTE_W-1:0]    i_data_byte,
    input  l2h_pkg::t_words               i_seeds,
    input  l2h_pkg::t_mix_item            i_done,
    input  logic                          i_pipe_busy,
    input  logic                          i_out_free,
    output l2h_pkg::t_mix_item            o_launch
);
    import l2h_pkg::*;

    logic              r_in_valid;
    logic              r_in_mode;
    logic [BYTE_W-1:0] r_in_byte;

    // base holds the last mixed words, delta the bytes added since then
    t_words            r_base;
    t_words            r_delta;
    t_words            n_delta;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [WORD_W-1:0] r_count;
    t_mix_item         r_launch;
    t_mix_item         n_launch;

    logic              advance;
    logic [POS_W-1:0]  pos_eff;
    logic [1:0]        word_sel;
    logic [1:0]        lane;
    logic [WORD_W-1:0] add;
    logic [WORD_W-1:0] c_extra;

    // a finish item waits for an empty mix pipeline and a free result register
    assign advance = r_in_valid && (!r_in_mode || (!i_pipe_busy && i_out_free));
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        pos_eff  = (r_pos > LAST_POS) ? '0 : r_pos;
        word_sel = pos_eff[3:2];
        lane     = pos_eff[1:0];
        add      = WORD_W'(r_in_byte) << {lane, 3'b000};
        c_extra  = r_in_mode ? r_count : add;

        n_delta  = r_delta;
        n_pos    = pos_eff + POS_W'(1);
        case (word_sel)
            2'd0:    n_delta.a = r_delta.a + add;
            2'd1:    n_delta.b = r_delta.b + add;
            default: n_delta.c = r_delta.c + add;
        endcase

        n_launch.valid   = advance && (r_in_mode || pos_eff == LAST_POS);
        n_launch.last    = r_in_mode;
        n_launch.words.a = r_base.a + r_delta.a;
        n_launch.words.b = r_base.b + r_delta.b;
        n_launch.words.c = r_base.c + r_delta.c + c_extra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base         <= '{a: SEED_A_RESET, b: SEED_B_RESET, c: SEED_C_RESET};
            r_delta        <= '0;
            r_pos          <= '0;
            r_count        <= '0;
            r_launch.valid <= 1'b0;
        end else begin
            r_launch.valid <= n_launch.valid;
            if (i_done.valid && !i_done.last) begin
                r_base <= i_done.words;
            end
            if (advance) begin
                if (r_in_mode) begin
                    // message done: back to the seeded start state
                    r_base  <= i_seeds;
                    r_delta <= '0;
                    r_pos   <= '0;
                    r_count <= '0;
                end else if (pos_eff == LAST_POS) begin
                    r_delta <= '0;
                    r_pos   <= '0;
                    r_count <= r_count + WORD_W'(1);
                end else begin
                    r_delta <= n_delta;
                    r_pos   <= n_pos;
                    r_count <= r_count + WORD_W'(1);
                end
            end
        end
        r_launch.last  <= n_launch.last;
        r_launch.words <= n_launch.words;
    end

    assign o_launch = r_launch;

endmodule

// ----- src/lookup2_stream_hash.sv -----
`timescale 1ns / 1ps
// top level of the lookup2 stream hash: seed registers, result register
// depends on l2h_pkg, l2h_absorb, l2h_mix_pipe
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_mode, i_data_byte
// result    out        o_valid / i_ready    o_hash_value
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// data bytes are taken one per cycle unless a finish item waits; a twelve-byte
// block mixes in the background in a nine-stage pipeline while the next block is
// added into a delta set. a finish item waits until the mix pipeline is empty and
// the result register is free; the hash passes the launch and mix registers.
// synchronous active-low reset loads the seed reset values and empties all stages.
// a stalled result holds only a waiting finish item, and the input behind it.

module lookup2_stream_hash (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic [l2h_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [l2h_pkg::WORD_W-1:0]       o_hash_value,
    input  logic                             i_cfg_we,
    input  l2h_pkg::t_cfg_idx                i_cfg_index,
    input  logic [l2h_pkg::WORD_W-1:0]       i_cfg_data
);
    import l2h_pkg::*;

    t_words            r_seeds;
    t_mix_item         launch;
    t_mix_item         done;
    logic              mix_busy;
    logic              pipe_busy;
    logic              out_free;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeds <= '{a: SEED_A_RESET, b: SEED_B_RESET, c: SEED_C_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEED_A: r_seeds.a <= i_cfg_data;
                REG_SEED_B: r_seeds.b <= i_cfg_data;
                REG_SEED_C: r_seeds.c <= i_cfg_data;
                default:    r_seeds   <= r_seeds;
            endcase
        end
    end

    assign pipe_busy = launch.valid | mix_busy;
    assign out_free  = !r_out_valid || i_ready;

    l2h_absorb u_absorb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_seeds     (r_seeds),
        .i_done      (done),
        .i_pipe_busy (pipe_busy),
        .i_out_free  (out_free),
        .o_launch    (launch)
    );

    l2h_mix_pipe u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_launch (launch),
        .o_done   (done),
        .o_busy   (mix_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done.valid && done.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (done.valid && done.last) begin
            r_hash <= done.words.c;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

// ----- tb/l2h_check.sv -----
`timescale 1ns / 1ps
// checker for the lookup2 stream hash: watches the input, result and seed write ports,
// predicts each hash and compares it in order; depends on l2h_pkg

module l2h_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_mode,
    input  logic [l2h_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [l2h_pkg::WORD_W-1:0] i_hash_value,
    input  logic                       i_cfg_we,
    input  l2h_pkg::t_cfg_idx          i_cfg_index,
    input  logic [l2h_pkg::WORD_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    import l2h_pkg::*;

    t_words             seed_w;
    t_words             acc_w;
    t_words             fin_w;
    logic [POS_W-1:0]   lane_pos;
    logic [WORD_W-1:0]  byte_total;
    logic [WORD_W-1:0]  want_hash;
    logic [WORD_W-1:0]  expected_hash [$];

    // nine-round subtract/xor/shift scramble of the three accumulators
    function automatic t_words scramble(input t_words w);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        t_words r;
        a = w.a;
        b = w.b;
        c = w.c;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] data);
        logic [POS_W-1:0]  p;
        logic [WORD_W-1:0] addend;
        p = (lane_pos >= BLOCK_BYTES) ? '0 : lane_pos;
        // little-endian lane inside the selected word
        addend = WORD_W'(data) << (8 * p[1:0]);
        case (p[3:2])
            2'd0: acc_w.a = acc_w.a + addend;
            2'd1: acc_w.b = acc_w.b + addend;
            default: acc_w.c = acc_w.c + addend;
        endcase
        byte_total = byte_total + WORD_W'(1);
        p = p + POS_W'(1);
        if (p == BLOCK_BYTES) begin
            acc_w = scramble(acc_w);
            p = '0;
        end
        lane_pos = p;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns hash check: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_w.a   = SEED_A_RESET;
            seed_w.b   = SEED_B_RESET;
            seed_w.c   = SEED_C_RESET;
            acc_w      = seed_w;
            lane_pos   = '0;
            byte_total = '0;
            expected_hash.delete();
        end else begin
            // a new seed only shows at the next message start
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SEED_A: seed_w.a = i_cfg_data;
                    REG_SEED_B: seed_w.b = i_cfg_data;
                    REG_SEED_C: seed_w.c = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_mode) begin
                    absorb_byte(i_data_byte);
                end else begin
                    fin_w   = acc_w;
                    fin_w.c = fin_w.c + byte_total;
                    fin_w   = scramble(fin_w);
                    expected_hash.push_back(fin_w.c);
                    acc_w      = seed_w;
                    lane_pos   = '0;
                    byte_total = '0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_hash.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash %08h", i_hash_value));
                end else begin
                    want_hash = expected_hash.pop_front();
                    if (i_hash_value !== want_hash)
                        report_mismatch($sformatf("hash_value %08h, predicted %08h",
                                                  i_hash_value, want_hash));
                end
            end
        end
        o_pending = expected_hash.size();
    end

endmodule

// ----- tb/lookup2_stream_hash_test.sv -----
`timescale 1ns / 1ps
// testbench top for the lookup2 stream hash: clock, reset, seed programming, bursty
// message stimulus and result-side stalls; depends on l2h_pkg, l2h_check and the rtl

module lookup2_stream_hash_test;

    import l2h_pkg::*;

    localparam int        RUN_LIMIT   = 400000;
    localparam int        PHASE_ITEMS = 250;
    localparam int        HOLD_CYCLES = 400;
    localparam t_cfg_idx  REG_SPARE   = 2'd3;
    localparam logic      MODE_ABSORB = 1'b0;
    localparam logic      MODE_FINISH = 1'b1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_mode;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                o_valid;
    logic                i_ready;
    logic [WORD_W-1:0]   o_hash_value;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_index;
    logic [WORD_W-1:0]   i_cfg_data;

    int  fail_count;
    int  pending;
    int  cycle_count;
    int  burst_left;
    int  items_sent;
    bit  hold_go;

    lookup2_stream_hash u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    l2h_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_hash_value (o_hash_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: changing stall styles, plus one long hold-off on request
    initial begin
        int style;
        int span;
        int tick;
        bit held;
        held = 1'b0;
        tick = 0;
        i_ready = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_go && !held) begin
                    held = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                tick++;
                case (style)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_item(input logic mode, input logic [BYTE_W-1:0] data);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_message(input int len);
        repeat (len) begin
            if ($urandom_range(0, 7) == 0)
                push_item(MODE_ABSORB, $urandom_range(0, 1) ? 8'hFF : 8'h00);
            else
                push_item(MODE_ABSORB, BYTE_W'($urandom_range(0, 255)));
        end
        push_item(MODE_FINISH, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_messages(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(31, 150));
            else
                send_message($urandom_range(0, 30));
        end
    endtask

    // drop valid, drain every hash, then give the block time to go quiet
    task automatic settle();
        i_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic program_seeds(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                 input logic [WORD_W-1:0] c, input bit stray);
        t_cfg_idx          idx [4];
        logic [WORD_W-1:0] val [4];
        idx = '{REG_SEED_A, REG_SEED_B, REG_SEED_C, REG_SPARE};
        val = '{a, b, c, $urandom()};
        for (int k = 0; k < (stray ? 4 : 3); k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        hold_go     = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        cycle_count = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_mode      <= MODE_ABSORB;
        i_data_byte <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_SEED_A;
        i_cfg_data  <= '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty message, then lane extremes, then exactly one full block
        push_item(MODE_FINISH, 8'hA5);
        push_item(MODE_ABSORB, 8'h00);
        push_item(MODE_ABSORB, 8'hFF);
        push_item(MODE_ABSORB, 8'h01);
        push_item(MODE_ABSORB, 8'h80);
        push_item(MODE_FINISH, 8'h00);
        repeat (12) push_item(MODE_ABSORB, 8'hFF);
        push_item(MODE_FINISH, 8'h5A);
        run_messages(PHASE_ITEMS);
        settle();

        program_seeds('0, '0, '0, 1'b1);
        run_messages(PHASE_ITEMS);
        settle();

        program_seeds('1, '1, '1, 1'b0);
        run_messages(PHASE_ITEMS);
        settle();

        // result side held off while short messages keep coming
        hold_go    = 1'b1;
        burst_left = 1000;
        repeat (20) send_message($urandom_range(1, 6));
        settle();

        repeat (2) begin
            program_seeds($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            run_messages(PHASE_ITEMS);
            settle();
        end

        program_seeds(SEED_A_RESET, SEED_B_RESET, SEED_C_RESET, 1'b1);
        run_messages(PHASE_ITEMS);

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
